// ===== hdl/epdpk_pkg.sv =====
`default_nettype none

package epdpk_pkg;

   // Panel geometry
   localparam int PANEL_WIDTH  = 1440;
   localparam int PANEL_HEIGHT = 720;

   // Signed width that holds every mirrored or rotated coordinate
   localparam int CW = $clog2(PANEL_WIDTH + PANEL_HEIGHT + 4096) + 1;
   // Unsigned on-panel coordinate widths
   localparam int XW = $clog2(PANEL_WIDTH);
   localparam int YW = $clog2(PANEL_HEIGHT);

   // Framebuffer pitch in bytes per row
   localparam int PITCH_4BPP = PANEL_WIDTH / 2;
   localparam int PITCH_1BPP = (PANEL_WIDTH + 7) / 8;

   // Address arithmetic width, never below the output field width
   localparam int ADDR_W    = 19;
   localparam int AW_FULL   = $clog2(PANEL_HEIGHT * PITCH_4BPP + PANEL_WIDTH) + 1;
   localparam int AW_CALC   = (AW_FULL > ADDR_W) ? AW_FULL : ADDR_W;

   // Field widths
   localparam int RED_W   = 5;
   localparam int GREEN_W = 6;
   localparam int BLUE_W  = 5;
   localparam int PIX_W   = 11;
   localparam int MASK_W  = 8;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;
   localparam int REQ_PAD_W   = REQ_TDATA_W - (RED_W + GREEN_W + BLUE_W + 2 * PIX_W);
   localparam int RSP_PAD_W   = RSP_TDATA_W - (ADDR_W + 2 * MASK_W);

   // Register file
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAY_4BPP_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DITHER_ENABLE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLIP_SEL          = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATION_QUARTERS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOGICAL_WIDTH     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LOGICAL_HEIGHT    = 3'd5;

   localparam logic [PIX_W-1:0] LOGICAL_WIDTH_RST  = 11'd1440;
   localparam logic [PIX_W-1:0] LOGICAL_HEIGHT_RST = 11'd720;

   // Rotation codes
   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   // Byte masks
   localparam logic [MASK_W-1:0] MASK_HI_NIBBLE = 8'hF0;
   localparam logic [MASK_W-1:0] MASK_LO_NIBBLE = 8'h0F;
   localparam logic [MASK_W-1:0] MASK_MSB       = 8'h80;
   localparam logic [7:0]        FIXED_THRESH   = 8'd128;

   // 4x4 Bayer matrix, indexed {row, col}
   localparam logic [3:0] BAYER_TAB [16] = '{
      4'd0,  4'd8,  4'd2,  4'd10,
      4'd12, 4'd4,  4'd14, 4'd6,
      4'd3,  4'd11, 4'd1,  4'd9,
      4'd15, 4'd7,  4'd13, 4'd5
   };

   typedef struct packed {
      logic             gray_4bpp_mode;
      logic             dither_enable;
      logic [1:0]       flip_sel;
      logic [1:0]       rotation_quarters;
      logic [PIX_W-1:0] logical_width;
      logic [PIX_W-1:0] logical_height;
   } cfg_type;

   typedef struct packed {
      logic [PIX_W-1:0]   pixel_y;
      logic [PIX_W-1:0]   pixel_x;
      logic [BLUE_W-1:0]  blue;
      logic [GREEN_W-1:0] green;
      logic [RED_W-1:0]   red;
   } pix_type;

   typedef struct packed {
      logic [MASK_W-1:0] write_data;
      logic [MASK_W-1:0] write_mask;
      logic [ADDR_W-1:0] byte_address;
   } res_type;

endpackage

`default_nettype wire

// ===== hdl/epdpk_pixel_map.sv =====
`default_nettype none

module epdpk_pixel_map (
   input  epdpk_pkg::cfg_type cfg,
   input  epdpk_pkg::pix_type pix,
   output logic               hit,
   output epdpk_pkg::res_type res
);
   import epdpk_pkg::*;

   localparam logic signed [CW-1:0] PW_S = CW'(PANEL_WIDTH);
   localparam logic signed [CW-1:0] PH_S = CW'(PANEL_HEIGHT);
   localparam logic signed [CW-1:0] ONE_S = CW'(1);

   logic [7:0]  r8, g8, b8;
   logic [15:0] luma_sum;
   logic [7:0]  gray;

   logic signed [CW-1:0] lx, ly, dx, dy;
   logic [XW-1:0]        ux;
   logic [YW-1:0]        uy;
   logic [AW_CALC-1:0]   addr4, addr1;
   logic [MASK_W-1:0]    bit_mask;
   logic [7:0]           thresh;

   // Channel widening by bit replication and luma weighting
   assign r8 = {pix.red, pix.red[4:2]};
   assign g8 = {pix.green, pix.green[5:4]};
   assign b8 = {pix.blue, pix.blue[4:2]};
   assign luma_sum = 16'(r8) * 16'd76 + 16'(g8) * 16'd150 + 16'(b8) * 16'd30;
   assign gray = luma_sum[15:8];

   // Mirroring about the logical size, signed
   always_comb begin
      lx = CW'(pix.pixel_x);
      ly = CW'(pix.pixel_y);
      if (cfg.flip_sel[0]) begin
         lx = CW'(cfg.logical_width) - ONE_S - CW'(pix.pixel_x);
      end
      if (cfg.flip_sel[1]) begin
         ly = CW'(cfg.logical_height) - ONE_S - CW'(pix.pixel_y);
      end
   end

   // Rotation onto the panel
   always_comb begin
      unique case (cfg.rotation_quarters)
         ROT_90: begin
            dx = PW_S - ONE_S - ly;
            dy = lx;
         end
         ROT_180: begin
            dx = PW_S - ONE_S - lx;
            dy = PH_S - ONE_S - ly;
         end
         ROT_270: begin
            dx = ly;
            dy = PH_S - ONE_S - lx;
         end
         default: begin
            dx = lx;
            dy = ly;
         end
      endcase
   end

   assign hit = !dx[CW-1] && (dx < PW_S) && !dy[CW-1] && (dy < PH_S);
   assign ux  = dx[XW-1:0];
   assign uy  = dy[YW-1:0];

   // Row times pitch plus column byte
   assign addr4 = AW_CALC'(uy) * AW_CALC'(PITCH_4BPP) + AW_CALC'(ux >> 1);
   assign addr1 = AW_CALC'(uy) * AW_CALC'(PITCH_1BPP) + AW_CALC'(ux >> 3);

   assign bit_mask = MASK_MSB >> ux[2:0];
   assign thresh   = cfg.dither_enable ? {BAYER_TAB[{uy[1:0], ux[1:0]}], 4'b0000}
                                       : FIXED_THRESH;

   // Masked byte write
   always_comb begin
      if (cfg.gray_4bpp_mode) begin
         res.byte_address = addr4[ADDR_W-1:0];
         if (!ux[0]) begin
            res.write_mask = MASK_HI_NIBBLE;
            res.write_data = {gray[7:4], 4'b0000};
         end else begin
            res.write_mask = MASK_LO_NIBBLE;
            res.write_data = {4'b0000, gray[7:4]};
         end
      end else begin
         res.byte_address = addr1[ADDR_W-1:0];
         res.write_mask   = bit_mask;
         res.write_data   = (gray >= thresh) ? bit_mask : '0;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/rgb565_to_epd_pixel_packer_core.sv =====
`default_nettype none

// An accepted req beat loads the input register. Throughput: one pixel per cycle
// unless rsp_tready stalls, set by the single compute stage between the input
// register and the result register; off-panel pixels are dropped.
// Reset (synchronous, active high) empties both stages and loads the register
// defaults: 4bpp mode, dither on, no mirror, no rotation, 1440 x 720 logical.
module rgb565_to_epd_pixel_packer_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // red[4:0], green[10:5], blue[15:11], pixel_x[26:16], pixel_y[37:27], zero pad
   input  logic [epdpk_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // byte_address[18:0], write_mask[26:19], write_data[34:27], zero pad
   output logic [epdpk_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [epdpk_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [epdpk_pkg::CSR_DATA_W-1:0]     csr_data
);
   import epdpk_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    s1_valid_ff, s1_valid_in;
   pix_type s1_pix_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   res_type rsp_res_ff;

   logic    hit;
   res_type res;
   logic    rsp_load_en;
   logic    s1_go;
   logic    req_beat;

   // Register writes
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_GRAY_4BPP_MODE:    cfg_in.gray_4bpp_mode    = csr_data[0];
            CSR_DITHER_ENABLE:     cfg_in.dither_enable     = csr_data[0];
            CSR_FLIP_SEL:          cfg_in.flip_sel          = csr_data[1:0];
            CSR_ROTATION_QUARTERS: cfg_in.rotation_quarters = csr_data[1:0];
            CSR_LOGICAL_WIDTH:     cfg_in.logical_width     = csr_data[PIX_W-1:0];
            CSR_LOGICAL_HEIGHT:    cfg_in.logical_height    = csr_data[PIX_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gray_4bpp_mode    <= 1'b1;
         cfg_ff.dither_enable     <= 1'b1;
         cfg_ff.flip_sel          <= 2'd0;
         cfg_ff.rotation_quarters <= ROT_0;
         cfg_ff.logical_width     <= LOGICAL_WIDTH_RST;
         cfg_ff.logical_height    <= LOGICAL_HEIGHT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Compute stage
   epdpk_pixel_map u_pixel_map (
      .cfg (cfg_ff),
      .pix (s1_pix_ff),
      .hit (hit),
      .res (res)
   );

   // Flow control: a miss leaves stage 1 regardless of the output side
   assign rsp_load_en = !rsp_valid_ff || rsp_tready;
   assign s1_go       = s1_valid_ff && (!hit || rsp_load_en);
   assign req_tready  = !s1_valid_ff || s1_go;
   assign req_beat    = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load_en) begin
         rsp_valid_in = s1_valid_ff && hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_pix_ff <= pix_type'(req_tdata[REQ_TDATA_W-REQ_PAD_W-1:0]);
      end
      if (rsp_load_en && s1_valid_ff && hit) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_res_ff};

endmodule

`default_nettype wire

// ===== hdl/epdpk_checker.sv =====
`default_nettype none

module epdpk_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [epdpk_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready
);
   import epdpk_pkg::*;

   logic [MASK_W-1:0] mask;
   logic [MASK_W-1:0] data;

   assign mask = rsp_tdata[ADDR_W+MASK_W-1:ADDR_W];
   assign data = rsp_tdata[ADDR_W+2*MASK_W-1:ADDR_W+MASK_W];

   // Stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // Data only at masked bit positions
   a_data_in_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (data & ~mask) == '0)
      else $error("write_data outside write_mask");

   // Mask is a nibble or a single bit
   a_mask_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot(mask) || mask == MASK_HI_NIBBLE || mask == MASK_LO_NIBBLE)
      else $error("bad write_mask shape");

   // Reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   // A fresh result follows an earlier accepted pixel
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && !reset, 2))
      else $error("result without a matching accepted pixel");

endmodule

bind rgb565_to_epd_pixel_packer_core epdpk_checker u_checker (.*);

`default_nettype wire

// ===== test/rgb565_to_epd_pixel_packer_core_test.sv =====
`timescale 1ns / 100ps

module rgb565_to_epd_pixel_packer_core_test;
   import epdpk_pkg::*;

   // Spare register indexes: writes there must leave the settings alone
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   // Ordered-dither ranks, row-major over (y mod 4, x mod 4)
   localparam int DITHER_RANK [16] = '{
      0, 8, 2, 10,
      12, 4, 14, 6,
      3, 11, 1, 9,
      15, 7, 13, 5
   };

   localparam int PITCH_NIBBLE = PANEL_WIDTH / 2;
   localparam int PITCH_BIT    = (PANEL_WIDTH + 7) / 8;
   localparam int RAND_ITEMS   = 100;

   // Shadow settings plus the queue of framebuffer writes still owed
   class pixel_scoreboard;
      cfg_type regs;
      res_type writes_due[$];
      int      mismatches;

      function new();
         regs.gray_4bpp_mode    = 1'b1;
         regs.dither_enable     = 1'b1;
         regs.flip_sel          = 2'd0;
         regs.rotation_quarters = ROT_0;
         regs.logical_width     = 11'd1440;
         regs.logical_height    = 11'd720;
         mismatches             = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_GRAY_4BPP_MODE:    regs.gray_4bpp_mode    = val[0];
            CSR_DITHER_ENABLE:     regs.dither_enable     = val[0];
            CSR_FLIP_SEL:          regs.flip_sel          = val[1:0];
            CSR_ROTATION_QUARTERS: regs.rotation_quarters = val[1:0];
            CSR_LOGICAL_WIDTH:     regs.logical_width     = val[PIX_W-1:0];
            CSR_LOGICAL_HEIGHT:    regs.logical_height    = val[PIX_W-1:0];
            default: ;
         endcase
      endfunction

      // Gray conversion, mirror, rotation and byte packing; 0 when off panel
      function bit pack_pixel(pix_type p, output res_type w);
         int          r8, g8, b8, gray, lx, ly, dx, dy, thr;
         int unsigned ux, uy, addr;
         logic [7:0]  mask, data;
         w    = '0;
         r8   = {p.red, p.red[4:2]};
         g8   = {p.green, p.green[5:4]};
         b8   = {p.blue, p.blue[4:2]};
         gray = (r8 * 76 + g8 * 150 + b8 * 30) >> 8;
         lx   = p.pixel_x;
         ly   = p.pixel_y;
         if (regs.flip_sel[0]) lx = int'(regs.logical_width) - 1 - lx;
         if (regs.flip_sel[1]) ly = int'(regs.logical_height) - 1 - ly;
         case (regs.rotation_quarters)
            ROT_90: begin
               dx = PANEL_WIDTH - 1 - ly;
               dy = lx;
            end
            ROT_180: begin
               dx = PANEL_WIDTH - 1 - lx;
               dy = PANEL_HEIGHT - 1 - ly;
            end
            ROT_270: begin
               dx = ly;
               dy = PANEL_HEIGHT - 1 - lx;
            end
            default: begin
               dx = lx;
               dy = ly;
            end
         endcase
         if (dx < 0 || dx >= PANEL_WIDTH || dy < 0 || dy >= PANEL_HEIGHT) return 1'b0;
         ux = dx;
         uy = dy;
         if (regs.gray_4bpp_mode) begin
            addr = uy * PITCH_NIBBLE + (ux >> 1);
            if (ux[0] == 1'b0) begin
               mask = MASK_HI_NIBBLE;
               data = {gray[7:4], 4'h0};
            end else begin
               mask = MASK_LO_NIBBLE;
               data = {4'h0, gray[7:4]};
            end
         end else begin
            addr = uy * PITCH_BIT + (ux >> 3);
            mask = MASK_MSB >> ux[2:0];
            if (regs.dither_enable) thr = DITHER_RANK[{uy[1:0], ux[1:0]}] * 16;
            else thr = 128;
            data = (gray >= thr) ? mask : 8'h00;
         end
         w.byte_address = addr[ADDR_W-1:0];
         w.write_mask   = mask;
         w.write_data   = data;
         return 1'b1;
      endfunction

      function void note_pixel(pix_type p);
         res_type w;
         if (pack_pixel(p, w)) writes_due.push_back(w);
      endfunction

      function void check_result(res_type got);
         res_type want;
         if (writes_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected write: addr %0d mask %02h data %02h",
                        got.byte_address, got.write_mask, got.write_data);
            return;
         end
         want = writes_due.pop_front();
         if (got.byte_address != want.byte_address || got.write_mask != want.write_mask ||
             got.write_data != want.write_data) begin
            mismatches++;
            if (mismatches <= 10)
               $display("write mismatch: addr %0d/%0d mask %02h/%02h data %02h/%02h (exp/got)",
                        want.byte_address, got.byte_address, want.write_mask,
                        got.write_mask, want.write_data, got.write_data);
         end
      endfunction

      function int pending();
         return writes_due.size();
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   bit                      steady = 1'b0;
   pixel_scoreboard         sb = new();

   rgb565_to_epd_pixel_packer_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Run limit
   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 14);
   end

   // Result beats against the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(res_type'(rsp_tdata[ADDR_W+2*MASK_W-1:0]));
   end

   task automatic send_pixel(pix_type p);
      if (!steady) begin
         while ($urandom_range(99) < 14) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tdata  <= {{REQ_PAD_W{1'b0}}, p};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_pixel(p);
   endtask

   task automatic send_rgb(int r, int g, int b, int x, int y);
      pix_type p;
      p.red     = r[RED_W-1:0];
      p.green   = g[GREEN_W-1:0];
      p.blue    = b[BLUE_W-1:0];
      p.pixel_x = x[PIX_W-1:0];
      p.pixel_y = y[PIX_W-1:0];
      send_pixel(p);
   endtask

   // Stop sending until every owed write is out, then let the pipe settle
   task automatic drain_writes();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(idx, val);
   endtask

   // Narrow registers get random upper bits, which the block must drop
   task automatic apply_setting(bit gray, bit dither, logic [1:0] mirror, logic [1:0] rot,
                                logic [PIX_W-1:0] lw, logic [PIX_W-1:0] lh);
      drain_writes();
      write_register(CSR_GRAY_4BPP_MODE, {10'($urandom), gray});
      write_register(CSR_DITHER_ENABLE, {10'($urandom), dither});
      write_register(CSR_FLIP_SEL, {9'($urandom), mirror});
      write_register(CSR_ROTATION_QUARTERS, {9'($urandom), rot});
      write_register(CSR_LOGICAL_WIDTH, lw);
      write_register(CSR_LOGICAL_HEIGHT, lh);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int edge_coord(int logical);
      case ($urandom_range(7))
         0: return 0;
         1: return 1;
         2: return (logical - 1) & 11'h7FF;
         3: return logical;
         4: return PANEL_WIDTH - 1;
         5: return PANEL_WIDTH;
         6: return PANEL_HEIGHT - 1;
         default: return 2047;
      endcase
   endfunction

   // Mostly on-panel coordinates for the current rotation, plus noise and edges
   function automatic pix_type rand_pixel();
      pix_type p;
      int      pick, span_x, span_y;
      p.red   = 5'($urandom);
      p.green = 6'($urandom);
      p.blue  = 5'($urandom);
      if ($urandom_range(9) == 0) begin
         if ($urandom_range(1) == 0) p[15:0] = 16'h0000;
         else p[15:0] = 16'hFFFF;
      end
      pick = $urandom_range(99);
      if (pick < 75) begin
         span_x = sb.regs.rotation_quarters[0] ? PANEL_HEIGHT : PANEL_WIDTH;
         span_y = sb.regs.rotation_quarters[0] ? PANEL_WIDTH : PANEL_HEIGHT;
         p.pixel_x = 11'($urandom_range(span_x - 1));
         p.pixel_y = 11'($urandom_range(span_y - 1));
      end else if (pick < 88) begin
         p.pixel_x = 11'($urandom);
         p.pixel_y = 11'($urandom);
      end else begin
         p.pixel_x = 11'(edge_coord(sb.regs.logical_width));
         p.pixel_y = 11'(edge_coord(sb.regs.logical_height));
      end
      return p;
   endfunction

   task automatic send_random(int count);
      for (int i = 0; i < count; i++) send_pixel(rand_pixel());
   endtask

   initial begin
      logic [PIX_W-1:0] lw_pick [6];
      logic [PIX_W-1:0] lh_pick [6];
      lw_pick = '{11'd2047, 11'd1, 11'd0, 11'd1440, 11'($urandom), 11'($urandom)};
      lh_pick = '{11'd1, 11'd2047, 11'd720, 11'd0, 11'($urandom), 11'($urandom)};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: 4bpp nibbles, panel corners and off-panel edges
      send_rgb(0, 0, 0, 0, 0);
      send_rgb(31, 63, 31, 1439, 719);
      send_rgb(31, 0, 0, 1, 0);
      send_rgb(0, 63, 0, 1438, 719);
      send_rgb(0, 0, 31, 1440, 0);
      send_rgb(31, 63, 31, 0, 720);
      send_rgb(31, 63, 31, 2047, 2047);
      send_rgb(16, 32, 16, 719, 359);
      send_random(RAND_ITEMS);

      // 1bpp with dither: zero rank always white, every bit position of a byte
      apply_setting(1'b0, 1'b1, 2'd0, ROT_0, 11'd1440, 11'd720);
      send_rgb(0, 0, 0, 0, 0);
      send_rgb(0, 0, 0, 1, 0);
      send_rgb(31, 63, 31, 3, 3);
      for (int x = 2; x < 8; x++) send_rgb(8, 16, 8, x, 1);
      send_rgb(31, 63, 31, 1439, 719);
      send_random(RAND_ITEMS);

      // Fixed threshold, both mirrors, half turn; sender holds off mid-way
      apply_setting(1'b0, 1'b0, 2'd3, ROT_180, 11'd1440, 11'd720);
      send_rgb(16, 32, 16, 0, 0);
      send_rgb(15, 31, 15, 1439, 719);
      send_random(RAND_ITEMS / 2);
      drain_writes();
      send_random(RAND_ITEMS / 2);

      // Mirroring with a zero width goes negative and falls off the panel
      apply_setting(1'b1, 1'b1, 2'd3, ROT_90, 11'd0, 11'd2047);
      send_rgb(31, 63, 31, 0, 0);
      send_rgb(31, 63, 31, 5, 2047);

      // Random modes, every mirror and rotation, size extremes among them; one phase runs without gaps
      for (int k = 0; k < 6; k++) begin
         apply_setting(1'($urandom), 1'($urandom), 2'(k), (k < 4) ? 2'(3 - k) : 2'($urandom),
                       lw_pick[k], lh_pick[k]);
         if (k == 1) begin
            write_register(CSR_SPARE_LO, 11'($urandom));
            write_register(CSR_SPARE_HI, 11'($urandom));
            csr_valid <= 1'b0;
            @(posedge clock);
         end
         steady = (k == 2);
         send_random(RAND_ITEMS);
      end
      steady = 1'b0;

      drain_writes();
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/epdpk_pkg.sv
hdl/epdpk_pixel_map.sv
hdl/rgb565_to_epd_pixel_packer_core.sv
hdl/epdpk_checker.sv
test/rgb565_to_epd_pixel_packer_core_test.sv
